[hdl/psnr_pkg.sv]
// PSNR metric package: widths, constants, sequencer states and normaliser status.
// No dependencies; imported by every module of the PSNR block.
`timescale 1ns / 1ps

package psnr_pkg;

    localparam int MAX_PIXELS_LOG2 = 24;
    localparam int PIX_W    = 8;
    localparam int CNT_W    = MAX_PIXELS_LOG2 + 1;
    localparam int SSE_W    = MAX_PIXELS_LOG2 + 18;
    localparam int NRM_W    = SSE_W + 1;
    localparam int MANT_W   = 31;
    localparam int EXP_W    = 6;
    localparam int FRAC_W   = 24;
    localparam int LOG_W    = EXP_W + FRAC_W;
    localparam int ITER_W   = 5;
    localparam int MUL_W    = 32;
    localparam int PROD_W   = 2 * MUL_W;
    localparam int PSNR_W   = 15;
    localparam int RND_BIT  = 40;
    localparam int RND_W    = PROD_W - RND_BIT;
    localparam int IN_DATA_W  = 48;
    localparam int OUT_DATA_W = 64;

    localparam logic [CNT_W-1:0]  CNT_MAX   = {CNT_W{1'b1}};
    localparam logic [SSE_W-1:0]  SSE_MAX   = {SSE_W{1'b1}};
    localparam logic [MUL_W-1:0]  PEAK_X3   = MUL_W'(195075);
    localparam logic [MUL_W-1:0]  TEN_LOG2  = MUL_W'(50504453);
    localparam logic [PSNR_W-1:0] PSNR_SAT  = PSNR_W'(32767);
    localparam logic [PSNR_W-1:0] PSNR_SAME = PSNR_W'(25600);
    localparam logic [EXP_W-1:0]  EXP_TOP   = EXP_W'(NRM_W - 1);
    localparam logic [ITER_W-1:0] ITER_LAST = ITER_W'(FRAC_W - 1);
    localparam logic [PROD_W-1:0] RND_HALF  = PROD_W'(1) << (RND_BIT - 1);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SQ,
        ST_CHK,
        ST_CNT_CAP,
        ST_NORM,
        ST_LOG_MUL,
        ST_LOG_UPD,
        ST_SCALE_MUL,
        ST_SCALE_CAP,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic              done;
        logic [EXP_W-1:0]  exponent;
        logic [MANT_W-1:0] mantissa;
    } t_norm_stat;

endpackage

[hdl/psnr_mul.sv]
// Shared 32x32 unsigned multiplier with registered product.
// Depends on psnr_pkg.
`timescale 1ns / 1ps

module psnr_mul (
    input  logic                          i_clk,
    input  logic [psnr_pkg::MUL_W-1:0]    i_a,
    input  logic [psnr_pkg::MUL_W-1:0]    i_b,
    output logic [psnr_pkg::PROD_W-1:0]   o_prod
);
    import psnr_pkg::*;

    logic [PROD_W-1:0] r_prod;

    always_ff @(posedge i_clk) begin
        r_prod <= PROD_W'(i_a) * PROD_W'(i_b);
    end

    assign o_prod = r_prod;

endmodule

[hdl/psnr_norm.sv]
// Leading-one normaliser: shifts by eight or one bit a cycle, tracks the exponent.
// Depends on psnr_pkg.
`timescale 1ns / 1ps

module psnr_norm (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [psnr_pkg::NRM_W-1:0]    i_value,
    output psnr_pkg::t_norm_stat          o_stat
);
    import psnr_pkg::*;

    logic              r_busy;
    logic [NRM_W-1:0]  r_x;
    logic [EXP_W-1:0]  r_e;
    logic              w_top;

    assign w_top = r_x[NRM_W-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (i_start) begin
            r_busy <= 1'b1;
        end else if (w_top) begin
            r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_x <= i_value;
            r_e <= EXP_TOP;
        end else if (r_busy && !w_top) begin
            if (r_x[NRM_W-1 -: 8] == 8'd0) begin
                r_x <= r_x << 8;
                r_e <= r_e - EXP_W'(8);
            end else begin
                r_x <= r_x << 1;
                r_e <= r_e - EXP_W'(1);
            end
        end
    end

    assign o_stat.done     = r_busy & w_top;
    assign o_stat.exponent = r_e;
    assign o_stat.mantissa = r_x[NRM_W-1 -: MANT_W];

endmodule

[hdl/image_psnr_metric_core.sv]
// PSNR meter top level: sequencer, error/pixel sums, fixed-point log and result register.
// Depends on psnr_pkg, psnr_mul and psnr_norm.
//
// channel  | valid/ready              | payload
// ---------+--------------------------+-------------------------------------------
// pixel in | i_s_tvalid / o_s_tready  | i_s_tdata (6 samples), i_s_tlast
// result   | o_m_tvalid / i_m_tready  | o_m_tdata (psnr, sse), o_m_tuser (identical)
//
// A pixel is accepted, then squared channel by channel: three squarings on the shared multiplier.
// A last pixel with a nonzero error sum adds two log2 passes of 24 squarings each on
// the multiplier, plus normalisation and, unless the result is zero, scaling.
// Ready is high only in idle; a waiting result stalls only the next image's end.
// Synchronous active-low reset clears sums, sequencer and result valid.
`timescale 1ns / 1ps

module image_psnr_metric_core (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_s_tvalid,
    output logic                                 o_s_tready,
    // ref_red, ref_green, ref_blue, cmp_red, cmp_green, cmp_blue
    input  logic [psnr_pkg::IN_DATA_W-1:0]       i_s_tdata,
    input  logic                                 i_s_tlast,
    output logic                                 o_m_tvalid,
    input  logic                                 i_m_tready,
    // psnr_fixed, squared_error_sum, zero pad
    output logic [psnr_pkg::OUT_DATA_W-1:0]      o_m_tdata,
    // identical
    output logic                                 o_m_tuser
);
    import psnr_pkg::*;

    t_state             r_state, n_state;
    logic [PIX_W-1:0]   r_dr, r_dg, r_db;
    logic               r_last;
    logic [1:0]         r_idx;
    logic [CNT_W-1:0]   r_cnt, n_cnt;
    logic [SSE_W-1:0]   r_acc, n_acc;
    logic [MANT_W-1:0]  r_m;
    logic [EXP_W-1:0]   r_e;
    logic [FRAC_W-1:0]  r_frac;
    logic [ITER_W-1:0]  r_iter;
    logic               r_pass;
    logic [LOG_W-1:0]   r_ln;
    logic [LOG_W-1:0]   r_dlog;
    logic [PSNR_W-1:0]  r_res_psnr;
    logic               r_res_ident;
    logic               r_ovalid;
    logic [PSNR_W-1:0]  r_o_psnr;
    logic               r_o_ident;
    logic [SSE_W-1:0]   r_o_sse;

    logic [MUL_W-1:0]   w_mul_a, w_mul_b;
    logic [PROD_W-1:0]  w_prod;
    logic               w_norm_start;
    logic [NRM_W-1:0]   w_norm_val;
    t_norm_stat         w_norm;
    logic               w_accept;
    logic               w_out_free;
    logic [SSE_W:0]     w_sum;
    logic [PIX_W-1:0]   w_sq_op;
    logic [FRAC_W-1:0]  w_frac_nx;
    logic [MANT_W-1:0]  w_m_nx;
    logic [LOG_W-1:0]   w_ld;
    logic [PROD_W-1:0]  w_rnd_sum;
    logic [RND_W-1:0]   w_rnd;

    function automatic logic [PIX_W-1:0] abs_diff(input logic [PIX_W-1:0] a,
                                                  input logic [PIX_W-1:0] b);
        return (a >= b) ? (a - b) : (b - a);
    endfunction

    psnr_mul u_mul (
        .i_clk  (i_clk),
        .i_a    (w_mul_a),
        .i_b    (w_mul_b),
        .o_prod (w_prod)
    );

    psnr_norm u_norm (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_norm_start),
        .i_value (w_norm_val),
        .o_stat  (w_norm)
    );

    assign w_accept   = i_s_tvalid && (r_state == ST_IDLE);
    assign o_s_tready = (r_state == ST_IDLE);
    assign w_out_free = !r_ovalid || i_m_tready;

    assign w_sum     = {1'b0, r_acc} + (SSE_W+1)'(w_prod[2*PIX_W-1:0]);
    assign w_frac_nx = {r_frac[FRAC_W-2:0], w_prod[2*MANT_W-1]};
    assign w_m_nx    = w_prod[2*MANT_W-1] ? w_prod[2*MANT_W-1 -: MANT_W]
                                          : w_prod[2*MANT_W-2 -: MANT_W];
    assign w_ld      = {r_e, w_frac_nx};
    assign w_rnd_sum = w_prod + RND_HALF;
    assign w_rnd     = w_rnd_sum[PROD_W-1:RND_BIT];

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:      if (w_accept) n_state = ST_SQ;
            ST_SQ:        if (r_idx == 2'd3) n_state = r_last ? ST_CHK : ST_IDLE;
            ST_CHK:       n_state = (r_acc == '0) ? ST_OUT : ST_CNT_CAP;
            ST_CNT_CAP:   n_state = ST_NORM;
            ST_NORM:      if (w_norm.done) n_state = ST_LOG_MUL;
            ST_LOG_MUL:   n_state = ST_LOG_UPD;
            ST_LOG_UPD: begin
                if (r_iter != ITER_LAST) begin
                    n_state = ST_LOG_MUL;
                end else if (!r_pass) begin
                    n_state = ST_NORM;
                end else begin
                    n_state = (r_ln <= w_ld) ? ST_OUT : ST_SCALE_MUL;
                end
            end
            ST_SCALE_MUL: n_state = ST_SCALE_CAP;
            ST_SCALE_CAP: n_state = ST_OUT;
            ST_OUT:       if (w_out_free) n_state = ST_IDLE;
            default:      n_state = ST_IDLE;
        endcase
    end

    // shared unit operands and normaliser launch
    always_comb begin
        w_mul_a      = '0;
        w_mul_b      = '0;
        w_norm_start = 1'b0;
        w_norm_val   = {1'b0, r_acc};
        unique case (r_idx)
            2'd0:    w_sq_op = r_dr;
            2'd1:    w_sq_op = r_dg;
            2'd2:    w_sq_op = r_db;
            default: w_sq_op = '0;
        endcase
        unique case (r_state)
            ST_SQ: begin
                w_mul_a = MUL_W'(w_sq_op);
                w_mul_b = MUL_W'(w_sq_op);
            end
            ST_CHK: begin
                w_mul_a = MUL_W'(r_cnt);
                w_mul_b = PEAK_X3;
            end
            ST_CNT_CAP: begin
                w_norm_start = 1'b1;
                w_norm_val   = w_prod[NRM_W-1:0];
            end
            ST_LOG_MUL: begin
                w_mul_a = MUL_W'(r_m);
                w_mul_b = MUL_W'(r_m);
            end
            ST_LOG_UPD:   w_norm_start = (r_iter == ITER_LAST) && !r_pass;
            ST_SCALE_MUL: begin
                w_mul_a = MUL_W'(r_dlog);
                w_mul_b = TEN_LOG2;
            end
            default: ;
        endcase
    end

    // sums
    always_comb begin
        n_acc = r_acc;
        n_cnt = r_cnt;
        unique case (r_state)
            ST_IDLE: if (w_accept && r_cnt != CNT_MAX) n_cnt = r_cnt + CNT_W'(1);
            ST_SQ:   if (r_idx != 2'd0) n_acc = w_sum[SSE_W] ? SSE_MAX : w_sum[SSE_W-1:0];
            ST_OUT: if (w_out_free) begin
                n_acc = '0;
                n_cnt = '0;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_acc    <= '0;
            r_cnt    <= '0;
            r_ovalid <= 1'b0;
            r_idx    <= '0;
            r_iter   <= '0;
            r_pass   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_acc   <= n_acc;
            r_cnt   <= n_cnt;
            if (r_state == ST_OUT && w_out_free) begin
                r_ovalid <= 1'b1;
            end else if (i_m_tready) begin
                r_ovalid <= 1'b0;
            end
            if (w_accept) begin
                r_idx <= '0;
            end else if (r_state == ST_SQ) begin
                r_idx <= r_idx + 2'd1;
            end
            if (r_state == ST_CNT_CAP) begin
                r_pass <= 1'b0;
            end else if (r_state == ST_LOG_UPD && r_iter == ITER_LAST) begin
                r_pass <= 1'b1;
            end
            if (r_state == ST_NORM) begin
                r_iter <= '0;
            end else if (r_state == ST_LOG_UPD) begin
                r_iter <= r_iter + ITER_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_dr   <= abs_diff(i_s_tdata[0*PIX_W +: PIX_W], i_s_tdata[3*PIX_W +: PIX_W]);
            r_dg   <= abs_diff(i_s_tdata[1*PIX_W +: PIX_W], i_s_tdata[4*PIX_W +: PIX_W]);
            r_db   <= abs_diff(i_s_tdata[2*PIX_W +: PIX_W], i_s_tdata[5*PIX_W +: PIX_W]);
            r_last <= i_s_tlast;
        end
        if (r_state == ST_CHK) begin
            r_res_psnr  <= PSNR_SAME;
            r_res_ident <= 1'b1;
        end
        if (r_state == ST_NORM && w_norm.done) begin
            r_m    <= w_norm.mantissa;
            r_e    <= w_norm.exponent;
            r_frac <= '0;
        end
        if (r_state == ST_LOG_UPD) begin
            r_m    <= w_m_nx;
            r_frac <= w_frac_nx;
            if (r_iter == ITER_LAST) begin
                if (!r_pass) begin
                    r_ln <= w_ld;
                end else begin
                    r_dlog      <= r_ln - w_ld;
                    r_res_psnr  <= '0;
                    r_res_ident <= 1'b0;
                end
            end
        end
        if (r_state == ST_SCALE_CAP) begin
            r_res_psnr <= (w_rnd > RND_W'(PSNR_SAT)) ? PSNR_SAT : w_rnd[PSNR_W-1:0];
        end
        if (r_state == ST_OUT && w_out_free) begin
            r_o_psnr  <= r_res_psnr;
            r_o_ident <= r_res_ident;
            r_o_sse   <= r_acc;
        end
    end

    assign o_m_tvalid = r_ovalid;
    assign o_m_tuser  = r_o_ident;
    assign o_m_tdata  = {{(OUT_DATA_W-PSNR_W-SSE_W){1'b0}}, r_o_sse, r_o_psnr};

endmodule
